@@ rtl/core/crpe_pkg.sv @@
`default_nettype none
package crpe_pkg;

  localparam int COORD_W = 32;
  localparam int ALPHA_W = 17;
  localparam int COUNT_W = 5;
  // coefficient and horner accumulator width, holds 24 * 2^31 with sign
  localparam int ACC_W   = 38;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                      kind;
    logic [3:0]                point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [ALPHA_W-1:0]        alpha;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic wr;
    logic zero;
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/catmull_rom_path_evaluator.sv @@
`default_nettype none
// Uniform Catmull-Rom path evaluator over a table of up to MAX_POINTS 3D waypoints.
// Input channel: an item is taken on a clock edge with start high and busy low.
// busy is never raised, so one transaction can be issued every cycle. A write
// transaction (kind = 0) stores coord_x/y/z in slot point_index; an evaluate
// transaction (kind = 1) samples the path at alpha, clamped to 1.0.
// Result channel: out_valid is high for one cycle with pos_x/y/z; it must be
// taken in that cycle. Only evaluate transactions produce a result.
// Pipeline: eleven register stages: capture, segment select, point memory read,
// coefficients, three multiply/round steps of two stages each, saturate.
// Throughput: one transaction per cycle; writes and evaluates may interleave
// freely and an evaluate sees every write issued before it.
// Configuration: cfg_we/cfg_wdata load point_count; change it only when no
// evaluate is in flight.
// Reset: point_count returns to 0 and the pipeline empties; the waypoint
// memory keeps its contents and slots must be written before they are used.
module catmull_rom_path_evaluator #(
  parameter int MAX_POINTS      = 16,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire crpe_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  output crpe_pkg::out_item_t                  out_item,
  input  wire logic                            cfg_we,
  input  wire logic [crpe_pkg::COUNT_W-1:0]    cfg_wdata
);
  import crpe_pkg::*;

  localparam int IW       = $clog2(MAX_POINTS);
  localparam int TW       = ALPHA_FRAC_BITS + 1;
  localparam int LANE_LAT = 8;

  logic [COUNT_W-1:0] point_count_r;
  logic               s1_valid_r;
  in_item_t           s1_item_r;
  logic [COUNT_W-1:0] s1_count_r;
  in_item_t           s1_item_nxt;
  logic [COUNT_W-1:0] s1_count_nxt;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    s1_item_nxt = in_item;
    if (32'(in_item.alpha) > (32'(1) << ALPHA_FRAC_BITS)) begin
      s1_item_nxt.alpha = ALPHA_W'(32'(1) << ALPHA_FRAC_BITS);
    end
    if (32'(point_count_r) > MAX_POINTS) begin
      s1_count_nxt = COUNT_W'(MAX_POINTS);
    end else begin
      s1_count_nxt = point_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        point_count_r <= cfg_wdata;
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    s1_count_r <= s1_count_nxt;
  end

  ctl_t          seg_ctl;
  logic [IW-1:0] wr_addr;
  point_t        wr_point;
  logic [IW-1:0] rd_addr0, rd_addr1, rd_addr2, rd_addr3;
  logic [TW-1:0] seg_t;

  crpe_seg #(
    .MAX_POINTS      (MAX_POINTS),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_seg (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (s1_valid_r),
    .item_i     (s1_item_r),
    .count_i    (s1_count_r),
    .ctl_o      (seg_ctl),
    .wr_addr_o  (wr_addr),
    .wr_point_o (wr_point),
    .rd_addr0_o (rd_addr0),
    .rd_addr1_o (rd_addr1),
    .rd_addr2_o (rd_addr2),
    .rd_addr3_o (rd_addr3),
    .t_o        (seg_t)
  );

  logic          st_valid;
  point_t        p0, p1, p2, p3;
  logic [TW-1:0] st_t;

  crpe_store #(
    .MAX_POINTS      (MAX_POINTS),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (seg_ctl),
    .wr_addr_i  (wr_addr),
    .wr_point_i (wr_point),
    .rd_addr0_i (rd_addr0),
    .rd_addr1_i (rd_addr1),
    .rd_addr2_i (rd_addr2),
    .rd_addr3_i (rd_addr3),
    .t_i        (seg_t),
    .valid_o    (st_valid),
    .p0_o       (p0),
    .p1_o       (p1),
    .p2_o       (p2),
    .p3_o       (p3),
    .t_o        (st_t)
  );

  crpe_lane #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_lane_x (
    .clk   (clk),
    .p0_i  (p0.x),
    .p1_i  (p1.x),
    .p2_i  (p2.x),
    .p3_i  (p3.x),
    .t_i   (st_t),
    .pos_o (out_item.pos_x)
  );

  crpe_lane #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_lane_y (
    .clk   (clk),
    .p0_i  (p0.y),
    .p1_i  (p1.y),
    .p2_i  (p2.y),
    .p3_i  (p3.y),
    .t_i   (st_t),
    .pos_o (out_item.pos_y)
  );

  crpe_lane #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_lane_z (
    .clk   (clk),
    .p0_i  (p0.z),
    .p1_i  (p1.z),
    .p2_i  (p2.z),
    .p3_i  (p3.z),
    .t_i   (st_t),
    .pos_o (out_item.pos_z)
  );

  // valid bits alongside the lane stages
  logic [LANE_LAT-1:0] vpipe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else begin
      vpipe_r <= {vpipe_r[LANE_LAT-2:0], st_valid};
    end
  end

  assign out_valid = vpipe_r[LANE_LAT-1];

`ifndef SYNTH
  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.kind == KIND_EVAL |-> ##11 out_valid)
    else $error("evaluate transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && in_item.kind == KIND_EVAL, 11))
    else $error("result without a matching evaluate transaction");

  a_empty_path_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(accept && point_count_r == '0, 11) |-> out_item == '0)
    else $error("empty path did not return zero");
`endif

endmodule
`default_nettype wire

@@ rtl/core/crpe_seg.sv @@
`default_nettype none
module crpe_seg #(
  parameter int MAX_POINTS      = 16,
  parameter int ALPHA_FRAC_BITS = 16,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int TW = ALPHA_FRAC_BITS + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      valid_i,
  input  wire crpe_pkg::in_item_t        item_i,
  input  wire logic [crpe_pkg::COUNT_W-1:0] count_i,
  output crpe_pkg::ctl_t                 ctl_o,
  output logic [IW-1:0]                  wr_addr_o,
  output crpe_pkg::point_t               wr_point_o,
  output logic [IW-1:0]                  rd_addr0_o,
  output logic [IW-1:0]                  rd_addr1_o,
  output logic [IW-1:0]                  rd_addr2_o,
  output logic [IW-1:0]                  rd_addr3_o,
  output logic [TW-1:0]                  t_o
);
  import crpe_pkg::*;

  localparam int SW = ALPHA_W + COUNT_W;
  localparam int XW = SW + ALPHA_FRAC_BITS;
  localparam logic [TW-1:0] ONE_T = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

  logic [COUNT_W-1:0] segs;
  logic [COUNT_W-1:0] last;
  logic               few_pts;
  logic [SW-1:0]      scaled;
  logic [XW-1:0]      sc_w;
  logic [COUNT_W-1:0] idx_raw;
  logic               at_end;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] i0;
  logic [COUNT_W-1:0] i2;
  logic [COUNT_W-1:0] i3;
  logic [TW-1:0]      t_nxt;
  logic               wr_drop;
  ctl_t               ctl_nxt;

  assign segs    = count_i - COUNT_W'(1);
  assign last    = segs - COUNT_W'(1);
  assign few_pts = (count_i < COUNT_W'(2));
  assign scaled  = SW'(item_i.alpha) * SW'(segs);
  assign sc_w    = XW'(scaled);
  assign idx_raw = COUNT_W'(sc_w >> ALPHA_FRAC_BITS);
  // alpha of exactly 1.0 lands one past the last segment
  assign at_end  = (idx_raw > last);

  always_comb begin
    idx   = at_end ? last : idx_raw;
    t_nxt = at_end ? ONE_T : {1'b0, sc_w[ALPHA_FRAC_BITS-1:0]};
    i0    = (idx == '0) ? '0 : idx - COUNT_W'(1);
    i2    = idx + COUNT_W'(1);
    i3    = ((idx + COUNT_W'(2)) < segs) ? idx + COUNT_W'(2) : segs;
    // fewer than two points: everything reads slot 0 at t = 0
    if (few_pts) begin
      idx   = '0;
      i0    = '0;
      i2    = '0;
      i3    = '0;
      t_nxt = '0;
    end
  end

  // a write to a slot past the table is dropped as a bubble
  assign wr_drop = (item_i.kind == KIND_WRITE) && (32'(item_i.point_index) >= MAX_POINTS);

  always_comb begin
    ctl_nxt.valid = valid_i && !wr_drop;
    ctl_nxt.wr    = (item_i.kind == KIND_WRITE);
    ctl_nxt.zero  = (count_i == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_o  <= IW'(item_i.point_index);
    wr_point_o <= '{x: item_i.coord_x, y: item_i.coord_y, z: item_i.coord_z};
    rd_addr0_o <= IW'(i0);
    rd_addr1_o <= IW'(idx);
    rd_addr2_o <= IW'(i2);
    rd_addr3_o <= IW'(i3);
    t_o        <= t_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/crpe_store.sv @@
`default_nettype none
module crpe_store #(
  parameter int MAX_POINTS      = 16,
  parameter int ALPHA_FRAC_BITS = 16,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int TW = ALPHA_FRAC_BITS + 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire crpe_pkg::ctl_t    ctl_i,
  input  wire logic [IW-1:0]     wr_addr_i,
  input  wire crpe_pkg::point_t  wr_point_i,
  input  wire logic [IW-1:0]     rd_addr0_i,
  input  wire logic [IW-1:0]     rd_addr1_i,
  input  wire logic [IW-1:0]     rd_addr2_i,
  input  wire logic [IW-1:0]     rd_addr3_i,
  input  wire logic [TW-1:0]     t_i,
  output logic                   valid_o,
  output crpe_pkg::point_t       p0_o,
  output crpe_pkg::point_t       p1_o,
  output crpe_pkg::point_t       p2_o,
  output crpe_pkg::point_t       p3_o,
  output logic [TW-1:0]          t_o
);
  import crpe_pkg::*;

  // two copies with two read ports each give the four control points per cycle
  point_t mem_a_r [MAX_POINTS];
  point_t mem_b_r [MAX_POINTS];

  logic wr_en;

  assign wr_en = ctl_i.valid && ctl_i.wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a_r[wr_addr_i] <= wr_point_i;
      mem_b_r[wr_addr_i] <= wr_point_i;
    end
    p0_o <= ctl_i.zero ? '0 : mem_a_r[rd_addr0_i];
    p1_o <= ctl_i.zero ? '0 : mem_a_r[rd_addr1_i];
    p2_o <= ctl_i.zero ? '0 : mem_b_r[rd_addr2_i];
    p3_o <= ctl_i.zero ? '0 : mem_b_r[rd_addr3_i];
    t_o  <= t_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= ctl_i.valid && !ctl_i.wr;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/crpe_lane.sv @@
`default_nettype none
module crpe_lane #(
  parameter int ALPHA_FRAC_BITS = 16,
  localparam int TW = ALPHA_FRAC_BITS + 1
) (
  input  wire logic                                clk,
  input  wire logic signed [crpe_pkg::COORD_W-1:0] p0_i,
  input  wire logic signed [crpe_pkg::COORD_W-1:0] p1_i,
  input  wire logic signed [crpe_pkg::COORD_W-1:0] p2_i,
  input  wire logic signed [crpe_pkg::COORD_W-1:0] p3_i,
  input  wire logic [TW-1:0]                       t_i,
  output logic signed [crpe_pkg::COORD_W-1:0]      pos_o
);
  import crpe_pkg::*;

  localparam int PW = ACC_W + TW + 1;
  localparam logic signed [PW-1:0]    HALF    = {{(PW-1){1'b0}}, 1'b1} <<< (ALPHA_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ONE_A   = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] s;
    s = (prod + HALF) >>> ALPHA_FRAC_BITS;
    return s[ACC_W-1:0];
  endfunction

  logic signed [ACC_W-1:0] e0, e1, e2, e3;
  logic signed [ACC_W-1:0] d12;

  assign e0  = {{(ACC_W-COORD_W){p0_i[COORD_W-1]}}, p0_i};
  assign e1  = {{(ACC_W-COORD_W){p1_i[COORD_W-1]}}, p1_i};
  assign e2  = {{(ACC_W-COORD_W){p2_i[COORD_W-1]}}, p2_i};
  assign e3  = {{(ACC_W-COORD_W){p3_i[COORD_W-1]}}, p3_i};
  assign d12 = e1 - e2;

  // stage: coefficients
  logic signed [ACC_W-1:0] c3_r, c2_r, c1_r, c0_r;
  logic [TW-1:0]           t0_r;

  always_ff @(posedge clk) begin
    c3_r <= e3 - e0 + (d12 <<< 1) + d12;
    c2_r <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c1_r <= e2 - e0;
    c0_r <= e1 <<< 1;
    t0_r <= t_i;
  end

  // horner steps 1 to 3: multiply, then round and add
  logic signed [TW:0]      ts0, ts1, ts2;
  logic signed [PW-1:0]    prod1_r, prod2_r, prod3_r;
  logic signed [ACC_W-1:0] c2a_r, c1a_r, c1b_r, c1c_r, c0a_r, c0b_r, c0c_r, c0d_r, c0e_r;
  logic [TW-1:0]           t1_r, t2_r, t3_r, t4_r;
  logic signed [ACC_W-1:0] acc1_r, acc2_r, acc3_r;

  assign ts0 = {1'b0, t0_r};
  assign ts1 = {1'b0, t2_r};
  assign ts2 = {1'b0, t4_r};

  always_ff @(posedge clk) begin
    prod1_r <= c3_r * ts0;
    c2a_r   <= c2_r;
    c1a_r   <= c1_r;
    c0a_r   <= c0_r;
    t1_r    <= t0_r;

    acc1_r  <= c2a_r + rnd(prod1_r);
    c1b_r   <= c1a_r;
    c0b_r   <= c0a_r;
    t2_r    <= t1_r;

    prod2_r <= acc1_r * ts1;
    c1c_r   <= c1b_r;
    c0c_r   <= c0b_r;
    t3_r    <= t2_r;

    acc2_r  <= c1c_r + rnd(prod2_r);
    c0d_r   <= c0c_r;
    t4_r    <= t3_r;

    prod3_r <= acc2_r * ts2;
    c0e_r   <= c0d_r;

    acc3_r  <= c0e_r + rnd(prod3_r);
  end

  // halve with ties upward, then saturate
  logic signed [ACC_W-1:0] halved;

  assign halved = (acc3_r + ONE_A) >>> 1;

  always_ff @(posedge clk) begin
    if (halved > SAT_MAX) begin
      pos_o <= SAT_MAX[COORD_W-1:0];
    end else if (halved < SAT_MIN) begin
      pos_o <= SAT_MIN[COORD_W-1:0];
    end else begin
      pos_o <= halved[COORD_W-1:0];
    end
  end

endmodule
`default_nettype wire
